// ===== src/psu_pkg.sv =====
package psu_pkg;

	localparam int ROW_WIDTH_BITS = 16;
	localparam int QUEUE_DEPTH    = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam int BYTE_BITS      = 8;

	typedef enum logic [1:0] {
		MODE_GRAY   = 2'd0,
		MODE_CHUNKY = 2'd1,
		MODE_PLANAR = 2'd2,
		MODE_MASK   = 2'd3
	} pixel_mode_t;

	typedef enum logic [1:0] {
		REG_BITS_PER_SAMPLE   = 2'd0,
		REG_SAMPLES_PER_PIXEL = 2'd1,
		REG_PIXEL_MODE        = 2'd2,
		REG_ROW_WIDTH         = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [1:0]  depth_log;
		pixel_mode_t mode;
		logic        stride4;
		logic [1:0]  cp0;
		logic [2:0]  last_kept;
		logic        end_flag;
	} job_t;

endpackage

// ===== src/psu_front.sv =====
module psu_front import psu_pkg::*; #(
	parameter int WIDTH_BITS = ROW_WIDTH_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               plane0_byte,
	input  logic [7:0]               plane1_byte,
	input  logic [7:0]               plane2_byte,
	input  logic                     queue_full,
	output logic                     push,
	output job_t                     job
);

	localparam int SLW = WIDTH_BITS + 2;

	logic [3:0]            bits_per_sample_q;
	logic [2:0]            samples_per_pixel_q;
	pixel_mode_t           pixel_mode_q;
	logic [WIDTH_BITS-1:0] row_width_q;
	logic [SLW-1:0]        samples_left_q;
	logic [1:0]            cp_q;

	logic [1:0]     depth_log;
	logic [3:0]     max_slots;
	logic           stride4;
	logic           chunky;
	logic [SLW-1:0] w_ext;
	logic [SLW-1:0] total;
	logic [SLW-1:0] sl_start;
	logic [1:0]     cp_start;
	logic [3:0]     n_slots;
	logic [SLW-1:0] sl_next;
	logic [1:0]     cp_last;
	logic [1:0]     cp_next;
	logic           drop_only;
	logic           accept;

	function automatic logic [1:0] cp_wrap(input logic [3:0] v, input logic s4);
		logic [3:0] r;
		if (s4) begin
			r = v & 4'd3;
		end else if (v >= 4'd9) begin
			r = v - 4'd9;
		end else if (v >= 4'd6) begin
			r = v - 4'd6;
		end else if (v >= 4'd3) begin
			r = v - 4'd3;
		end else begin
			r = v;
		end
		return r[1:0];
	endfunction

	always_comb begin
		case (bits_per_sample_q)
			4'd1:    depth_log = 2'd0;
			4'd2:    depth_log = 2'd1;
			4'd4:    depth_log = 2'd2;
			default: depth_log = 2'd3;
		endcase
		max_slots = 4'd8 >> depth_log;
		stride4   = (samples_per_pixel_q == 3'd4);
		chunky    = (pixel_mode_q == MODE_CHUNKY);
		w_ext     = SLW'(row_width_q);
		if (chunky) begin
			total = stride4 ? (w_ext << 2) : (w_ext + (w_ext << 1));
		end else begin
			total = w_ext;
		end
		sl_start  = (samples_left_q == '0) ? total : samples_left_q;
		cp_start  = (samples_left_q == '0) ? 2'd0 : cp_q;
		n_slots   = (sl_start < SLW'(max_slots)) ? sl_start[3:0] : max_slots;
		sl_next   = sl_start - SLW'(n_slots);
		cp_last   = cp_wrap(4'(cp_start) + n_slots - 4'd1, stride4);
		cp_next   = cp_wrap(4'(cp_start) + n_slots, stride4);
		drop_only = chunky && stride4 && (n_slots == 4'd1) && (cp_last == 2'd3);

		job.b0        = plane0_byte;
		job.b1        = plane1_byte;
		job.b2        = plane2_byte;
		job.depth_log = depth_log;
		job.mode      = pixel_mode_q;
		job.stride4   = stride4;
		job.cp0       = cp_start;
		job.last_kept = (chunky && stride4 && cp_last == 2'd3) ? 3'(n_slots - 4'd2)
			: 3'(n_slots - 4'd1);
		job.end_flag  = (sl_next == '0) ||
			(chunky && stride4 && sl_next == SLW'(1) && cp_last == 2'd2);
	end

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (n_slots != 4'd0) && !drop_only;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_per_sample_q   <= 4'd8;
			samples_per_pixel_q <= 3'd1;
			pixel_mode_q        <= MODE_GRAY;
			row_width_q         <= WIDTH_BITS'(1);
			samples_left_q      <= '0;
			cp_q                <= 2'd0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BITS_PER_SAMPLE:   bits_per_sample_q   <= cfg_data[3:0];
				REG_SAMPLES_PER_PIXEL: samples_per_pixel_q <= cfg_data[2:0];
				REG_PIXEL_MODE:        pixel_mode_q        <= pixel_mode_t'(cfg_data[1:0]);
				REG_ROW_WIDTH:         row_width_q         <= WIDTH_BITS'(cfg_data);
				default:               ;
			endcase
			samples_left_q <= '0;
			cp_q           <= 2'd0;
		end else if (accept) begin
			samples_left_q <= sl_next;
			cp_q           <= cp_next;
		end
	end

endmodule

// ===== src/psu_queue.sv =====
module psu_queue import psu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop)) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH)) else $error("queue count past depth");

endmodule

// ===== src/psu_back.sv =====
module psu_back import psu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head_job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] sample_value,
	output logic [1:0] channel,
	output logic       row_end,
	output logic       run_last
);

	logic [2:0] k_q;
	logic [1:0] sub_q;
	logic [1:0] cp_q;
	logic       out_valid_q;
	logic [7:0] sample_q;
	logic [1:0] channel_q;
	logic       row_end_q;
	logic       run_last_q;

	logic       can_load;
	logic       step;
	logic [1:0] cp_cur;
	logic [1:0] cp_adv;
	logic       planar;
	logic       dropped;
	logic       last_res;
	logic [7:0] src_byte;
	logic [2:0] shamt;
	logic [7:0] shifted;
	logic [7:0] raw;
	logic [7:0] value;
	logic [1:0] ch;

	always_comb begin
		can_load = !out_valid_q || out_ready;
		step     = head_valid && can_load;
		planar   = (head_job.mode == MODE_PLANAR);
		cp_cur   = (k_q == 3'd0) ? head_job.cp0 : cp_q;
		if (head_job.stride4) begin
			cp_adv = cp_cur + 2'd1;
		end else begin
			cp_adv = (cp_cur >= 2'd2) ? 2'd0 : cp_cur + 2'd1;
		end
		dropped  = (head_job.mode == MODE_CHUNKY) && (cp_cur == 2'd3);
		last_res = (k_q == head_job.last_kept) && (!planar || sub_q == 2'd2);

		case (planar ? sub_q : 2'd0)
			2'd1:    src_byte = head_job.b1;
			2'd2:    src_byte = head_job.b2;
			default: src_byte = head_job.b0;
		endcase
		shamt   = 3'(k_q << head_job.depth_log);
		shifted = src_byte << shamt;
		raw     = shifted >> (4'd8 - (4'd1 << head_job.depth_log));

		case (head_job.mode)
			MODE_MASK:   value = (raw != 8'd0) ? 8'd1 : 8'd0;
			default:     value = raw;
		endcase
		case (head_job.mode)
			MODE_PLANAR: ch = sub_q;
			MODE_CHUNKY: ch = cp_cur;
			default:     ch = 2'd0;
		endcase

		pop = step && last_res;
	end

	always_ff @(posedge clk) begin
		if (step && !dropped) begin
			sample_q   <= value;
			channel_q  <= ch;
			run_last_q <= last_res;
			row_end_q  <= last_res && head_job.end_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= 3'd0;
			sub_q       <= 2'd0;
			cp_q        <= 2'd0;
		end else begin
			if (can_load) begin
				out_valid_q <= step && !dropped;
			end
			if (step) begin
				if (last_res) begin
					k_q   <= 3'd0;
					sub_q <= 2'd0;
				end else if (planar && sub_q != 2'd2) begin
					sub_q <= sub_q + 2'd1;
				end else begin
					k_q   <= k_q + 3'd1;
					sub_q <= 2'd0;
					cp_q  <= cp_adv;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_value = sample_q;
	assign channel      = channel_q;
	assign row_end      = row_end_q;
	assign run_last     = run_last_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && row_end_q |-> run_last_q) else $error("row end off last result");
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> k_q <= head_job.last_kept) else $error("slot index past job");
	a_mid_job_head: assert property (@(posedge clk) disable iff (!arst_n)
		(k_q != 3'd0 || sub_q != 2'd0) |-> head_valid) else $error("job lost mid-walk");

endmodule

// ===== src/packed_sample_unpacker.sv =====
// A result is registered in the job queue, then in the output stage. Throughput: one result per
// cycle while m_axis_tready is set; a byte gives one result per kept sample slot (up to 8, or 24
// in planar mode at 1 bit), and dropped slots ahead of its last kept one also hold the output
// stage. A two-entry job queue lets the input take new bytes while earlier ones drain.
// Reset: registers return to their defaults, the row restarts, queue and output empty.
module packed_sample_unpacker import psu_pkg::*; #(
	parameter int WIDTH_BITS = ROW_WIDTH_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [23:0]              s_axis_tdata,  // plane0_byte, plane1_byte, plane2_byte
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [7:0]               m_axis_tdata,  // sample_value
	output logic [2:0]               m_axis_tuser,  // channel, row_end
	output logic                     m_axis_tlast
);

	logic full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head_job;
	logic [1:0] channel;
	logic row_end;

	psu_front #(.WIDTH_BITS(WIDTH_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.plane0_byte (s_axis_tdata[7:0]),
		.plane1_byte (s_axis_tdata[15:8]),
		.plane2_byte (s_axis_tdata[23:16]),
		.queue_full  (full),
		.push        (push),
		.job         (push_job)
	);

	psu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	psu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.sample_value (m_axis_tdata),
		.channel      (channel),
		.row_end      (row_end),
		.run_last     (m_axis_tlast)
	);

	assign m_axis_tuser = {row_end, channel};

endmodule
